// ===== rtl/hid_event_to_keycode_translator_assert.svh =====
// assertion macros for the hid event translator
// each macro takes a label, an antecedent and a consequent, checked on clk with rst_n low
// as the disable condition
`ifndef HID_EVENT_TO_KEYCODE_TRANSLATOR_ASSERT_SVH
`define HID_EVENT_TO_KEYCODE_TRANSLATOR_ASSERT_SVH
`ifndef SYNTH
`define HIDKC_ASSERT_SAME(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("hidkc assertion failed");
`define HIDKC_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("hidkc assertion failed");
`else
`define HIDKC_ASSERT_SAME(lbl, ante, cons)
`define HIDKC_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

// ===== rtl/hidkc_pkg.sv =====
`default_nettype none

package hidkc_pkg;

    // usage pages
    localparam logic [15:0] PAGE_DESKTOP  = 16'h0001;
    localparam logic [15:0] PAGE_KEYBOARD = 16'h0007;
    localparam logic [15:0] PAGE_BUTTON   = 16'h0009;
    localparam logic [15:0] PAGE_CONSUMER = 16'h000C;

    // generic desktop usages
    localparam logic [15:0] USAGE_X     = 16'h0030;
    localparam logic [15:0] USAGE_Y     = 16'h0031;
    localparam logic [15:0] USAGE_WHEEL = 16'h0038;

    // first pointer button code
    localparam logic [16:0] BUTTON_BASE = 17'h00110;

    // depth of the keyboard usage table
    localparam int unsigned KEY_TABLE_DEPTH = 256;

    // event kinds
    localparam logic [1:0] KIND_KEY    = 2'd0;
    localparam logic [1:0] KIND_BUTTON = 2'd1;
    localparam logic [1:0] KIND_MOTION = 2'd2;
    localparam logic [1:0] KIND_SCROLL = 2'd3;

    // item actions
    localparam logic ACTION_REPORT = 1'b0;
    localparam logic ACTION_TICK   = 1'b1;

    typedef struct packed {
        logic               action;
        logic [15:0]        page_id;
        logic [15:0]        usage_code;
        logic signed [31:0] report_value;
    } hid_in_t;

    typedef struct packed {
        logic [1:0]         event_kind;
        logic [16:0]        event_code;
        logic               pressed;
        logic signed [31:0] motion_x;
        logic signed [31:0] motion_y;
        logic signed [31:0] scroll_amount;
    } hid_out_t;

    typedef struct packed {
        logic       hit;
        logic [7:0] code;
    } media_lookup_t;

    // keyboard usage to key code, zero means no key
    function automatic logic [7:0] key_lookup(input logic [7:0] usage);
        logic [7:0] code;
        code = 8'd0;
        case (usage)
            8'h04: code = 8'd30;  8'h05: code = 8'd48;  8'h06: code = 8'd46;  8'h07: code = 8'd32;
            8'h08: code = 8'd18;  8'h09: code = 8'd33;  8'h0A: code = 8'd34;  8'h0B: code = 8'd35;
            8'h0C: code = 8'd23;  8'h0D: code = 8'd36;  8'h0E: code = 8'd37;  8'h0F: code = 8'd38;
            8'h10: code = 8'd50;  8'h11: code = 8'd49;  8'h12: code = 8'd24;  8'h13: code = 8'd25;
            8'h14: code = 8'd16;  8'h15: code = 8'd19;  8'h16: code = 8'd31;  8'h17: code = 8'd20;
            8'h18: code = 8'd22;  8'h19: code = 8'd47;  8'h1A: code = 8'd17;  8'h1B: code = 8'd45;
            8'h1C: code = 8'd21;  8'h1D: code = 8'd44;  8'h1E: code = 8'd2;   8'h1F: code = 8'd3;
            8'h20: code = 8'd4;   8'h21: code = 8'd5;   8'h22: code = 8'd6;   8'h23: code = 8'd7;
            8'h24: code = 8'd8;   8'h25: code = 8'd9;   8'h26: code = 8'd10;  8'h27: code = 8'd11;
            8'h28: code = 8'd28;  8'h29: code = 8'd1;   8'h2A: code = 8'd14;  8'h2B: code = 8'd15;
            8'h2C: code = 8'd57;  8'h2D: code = 8'd12;  8'h2E: code = 8'd13;  8'h2F: code = 8'd26;
            8'h30: code = 8'd27;  8'h31: code = 8'd43;  8'h32: code = 8'd43;  8'h33: code = 8'd39;
            8'h34: code = 8'd40;  8'h35: code = 8'd41;  8'h36: code = 8'd51;  8'h37: code = 8'd52;
            8'h38: code = 8'd53;  8'h39: code = 8'd58;  8'h3A: code = 8'd59;  8'h3B: code = 8'd60;
            8'h3C: code = 8'd61;  8'h3D: code = 8'd62;  8'h3E: code = 8'd63;  8'h3F: code = 8'd64;
            8'h40: code = 8'd65;  8'h41: code = 8'd66;  8'h42: code = 8'd67;  8'h43: code = 8'd68;
            8'h44: code = 8'd87;  8'h45: code = 8'd88;  8'h46: code = 8'd99;  8'h47: code = 8'd70;
            8'h48: code = 8'd119; 8'h49: code = 8'd110; 8'h4A: code = 8'd102; 8'h4B: code = 8'd104;
            8'h4C: code = 8'd111; 8'h4D: code = 8'd107; 8'h4E: code = 8'd109; 8'h4F: code = 8'd106;
            8'h50: code = 8'd105; 8'h51: code = 8'd108; 8'h52: code = 8'd103; 8'h53: code = 8'd69;
            8'h54: code = 8'd98;  8'h55: code = 8'd55;  8'h56: code = 8'd74;  8'h57: code = 8'd78;
            8'h58: code = 8'd96;  8'h59: code = 8'd79;  8'h5A: code = 8'd80;  8'h5B: code = 8'd81;
            8'h5C: code = 8'd75;  8'h5D: code = 8'd76;  8'h5E: code = 8'd77;  8'h5F: code = 8'd71;
            8'h60: code = 8'd72;  8'h61: code = 8'd73;  8'h62: code = 8'd82;  8'h63: code = 8'd83;
            8'h64: code = 8'd86;  8'h65: code = 8'd127; 8'h66: code = 8'd116; 8'h67: code = 8'd117;
            8'h68: code = 8'd183; 8'h69: code = 8'd184; 8'h6A: code = 8'd185; 8'h6B: code = 8'd186;
            8'h6C: code = 8'd187; 8'h6D: code = 8'd188; 8'h6E: code = 8'd189; 8'h6F: code = 8'd190;
            8'h70: code = 8'd191; 8'h71: code = 8'd192; 8'h72: code = 8'd193; 8'h73: code = 8'd194;
            8'h74: code = 8'd134; 8'h75: code = 8'd138; 8'h76: code = 8'd139; 8'h77: code = 8'd141;
            8'hE0: code = 8'd29;  8'hE1: code = 8'd42;  8'hE2: code = 8'd56;  8'hE3: code = 8'd125;
            8'hE4: code = 8'd97;  8'hE5: code = 8'd54;  8'hE6: code = 8'd100; 8'hE7: code = 8'd126;
            default: code = 8'd0;
        endcase
        return code;
    endfunction

    // consumer usage to media key code
    function automatic media_lookup_t media_lookup(input logic [15:0] usage);
        media_lookup_t res;
        res.hit  = 1'b1;
        res.code = 8'd0;
        case (usage)
            16'h006F: res.code = 8'd225;
            16'h0070: res.code = 8'd224;
            16'h00E2: res.code = 8'd113;
            16'h00E9: res.code = 8'd115;
            16'h00EA: res.code = 8'd114;
            16'h00B5: res.code = 8'd140;
            16'h0183: res.code = 8'd142;
            16'h0192: res.code = 8'd139;
            16'h0221: res.code = 8'd217;
            16'h0223: res.code = 8'd102;
            16'h0224: res.code = 8'd158;
            16'h0225: res.code = 8'd159;
            16'h0226: res.code = 8'd128;
            16'h0227: res.code = 8'd173;
            16'h022A: res.code = 8'd156;
            default:  res.hit  = 1'b0;
        endcase
        return res;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/hid_event_to_keycode_translator.sv =====
`default_nettype none

// Translates HID element reports into key, button, motion and scroll events. Each item is
// either one report or one motion flush tick, and yields at most one event. The block takes
// one item per clock: an item is captured in a report register, decoded by the key table,
// the media key list and one saturating motion adder, and its event is loaded into the
// result register. The combinational table lookup and the SUM_BITS-wide saturating add set
// the rate. X and Y reports fold into sums of SUM_BITS bits; a tick emits the sums,
// clamped to 32 bits, when either is nonzero and clears them. Input stalls only when
// the result register is full and not being taken while the captured item also produces
// an event.

`include "hid_event_to_keycode_translator_assert.svh"

module hid_event_to_keycode_translator
    import hidkc_pkg::*;
#(
    parameter int SUM_BITS = 32
)
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     report_valid,
    output logic          report_ready,
    input  wire hid_in_t  report,
    output logic          result_valid,
    input  wire logic     result_ready,
    output hid_out_t      result
);

    localparam int ADD_BITS = ((SUM_BITS > 32) ? SUM_BITS : 32) + 1;
    localparam logic signed [ADD_BITS-1:0] SUM_HI = ADD_BITS'({(SUM_BITS-1){1'b1}});
    localparam logic signed [ADD_BITS-1:0] SUM_LO = ~SUM_HI;
    localparam logic signed [ADD_BITS-1:0] OUT_HI = ADD_BITS'(32'h7FFF_FFFF);
    localparam logic signed [ADD_BITS-1:0] OUT_LO = ~OUT_HI;

    logic                       stage_valid_reg;
    logic                       stage_valid_next;
    hid_in_t                    stage_reg;
    logic                       result_valid_reg;
    logic                       result_valid_next;
    hid_out_t                   result_reg;
    hid_out_t                   result_next;
    logic signed [SUM_BITS-1:0] sum_x_reg;
    logic signed [SUM_BITS-1:0] sum_x_next;
    logic signed [SUM_BITS-1:0] sum_y_reg;
    logic signed [SUM_BITS-1:0] sum_y_next;

    logic                       has_result;
    logic                       out_free;
    logic                       stage_fire;
    logic                       report_fire;
    logic [7:0]                 key_code;
    media_lookup_t              media;
    logic                       pressed_bit;
    logic                       is_x;
    logic                       is_y;
    logic signed [SUM_BITS-1:0] sel_sum;
    logic signed [ADD_BITS-1:0] add_raw;
    logic signed [SUM_BITS-1:0] add_sat;
    logic signed [ADD_BITS-1:0] mx_ext;
    logic signed [ADD_BITS-1:0] my_ext;
    logic signed [31:0]         mx_out;
    logic signed [31:0]         my_out;

    // handshake
    assign out_free     = !result_valid_reg || result_ready;
    assign stage_fire   = stage_valid_reg && (!has_result || out_free);
    assign report_ready = !stage_valid_reg || stage_fire;
    assign report_fire  = report_valid && report_ready;
    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    // table lookups
    assign key_code    = key_lookup(stage_reg.usage_code[7:0]);
    assign media       = media_lookup(stage_reg.usage_code);
    assign pressed_bit = (stage_reg.report_value != 32'sd0);

    // saturating motion add, one adder shared by x and y
    assign is_x    = (stage_reg.page_id == PAGE_DESKTOP) && (stage_reg.usage_code == USAGE_X);
    assign is_y    = (stage_reg.page_id == PAGE_DESKTOP) && (stage_reg.usage_code == USAGE_Y);
    assign sel_sum = is_y ? sum_y_reg : sum_x_reg;
    assign add_raw = ADD_BITS'(sel_sum) + ADD_BITS'(stage_reg.report_value);

    always_comb
    begin
        if (add_raw > SUM_HI)
        begin
            add_sat = SUM_HI[SUM_BITS-1:0];
        end
        else if (add_raw < SUM_LO)
        begin
            add_sat = SUM_LO[SUM_BITS-1:0];
        end
        else
        begin
            add_sat = add_raw[SUM_BITS-1:0];
        end
    end

    // motion output clamped to 32 bits
    assign mx_ext = ADD_BITS'(sum_x_reg);
    assign my_ext = ADD_BITS'(sum_y_reg);

    always_comb
    begin
        if (mx_ext > OUT_HI)
        begin
            mx_out = OUT_HI[31:0];
        end
        else if (mx_ext < OUT_LO)
        begin
            mx_out = OUT_LO[31:0];
        end
        else
        begin
            mx_out = mx_ext[31:0];
        end
        if (my_ext > OUT_HI)
        begin
            my_out = OUT_HI[31:0];
        end
        else if (my_ext < OUT_LO)
        begin
            my_out = OUT_LO[31:0];
        end
        else
        begin
            my_out = my_ext[31:0];
        end
    end

    // decode of the captured item
    always_comb
    begin
        has_result                = 1'b0;
        result_next.event_kind    = KIND_KEY;
        result_next.event_code    = 17'd0;
        result_next.pressed       = 1'b0;
        result_next.motion_x      = 32'sd0;
        result_next.motion_y      = 32'sd0;
        result_next.scroll_amount = 32'sd0;
        if (stage_reg.action == ACTION_TICK)
        begin
            has_result             = (sum_x_reg != '0) || (sum_y_reg != '0);
            result_next.event_kind = KIND_MOTION;
            result_next.motion_x   = mx_out;
            result_next.motion_y   = my_out;
        end
        else
        begin
            unique case (stage_reg.page_id)
                PAGE_KEYBOARD:
                begin
                    has_result             = (stage_reg.usage_code < 16'(KEY_TABLE_DEPTH))
                                             && (key_code != 8'd0);
                    result_next.event_code = 17'(key_code);
                    result_next.pressed    = pressed_bit;
                end
                PAGE_BUTTON:
                begin
                    has_result             = 1'b1;
                    result_next.event_kind = KIND_BUTTON;
                    result_next.event_code = BUTTON_BASE + 17'(stage_reg.usage_code) - 17'd1;
                    result_next.pressed    = pressed_bit;
                end
                PAGE_DESKTOP:
                begin
                    has_result                = (stage_reg.usage_code == USAGE_WHEEL);
                    result_next.event_kind    = KIND_SCROLL;
                    result_next.scroll_amount = stage_reg.report_value;
                end
                PAGE_CONSUMER:
                begin
                    has_result             = media.hit;
                    result_next.event_code = 17'(media.code);
                    result_next.pressed    = pressed_bit;
                end
                default:
                begin
                    has_result = 1'b0;
                end
            endcase
        end
    end

    // motion sum update
    always_comb
    begin
        sum_x_next = sum_x_reg;
        sum_y_next = sum_y_reg;
        if (stage_fire)
        begin
            if (stage_reg.action == ACTION_TICK)
            begin
                sum_x_next = '0;
                sum_y_next = '0;
            end
            else if (is_x)
            begin
                sum_x_next = add_sat;
            end
            else if (is_y)
            begin
                sum_y_next = add_sat;
            end
        end
    end

    // valid flags
    assign stage_valid_next  = report_fire || (stage_valid_reg && !stage_fire);
    assign result_valid_next = (stage_fire && has_result) || (result_valid_reg && !result_ready);

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_valid_reg  <= 1'b0;
            result_valid_reg <= 1'b0;
            sum_x_reg        <= '0;
            sum_y_reg        <= '0;
        end
        else
        begin
            stage_valid_reg  <= stage_valid_next;
            result_valid_reg <= result_valid_next;
            sum_x_reg        <= sum_x_next;
            sum_y_reg        <= sum_y_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (report_fire)
        begin
            stage_reg <= report;
        end
        if (stage_fire && has_result)
        begin
            result_reg <= result_next;
        end
    end

    // checks
    `HIDKC_ASSERT_NEXT(a_tick_clears_sums, stage_fire && stage_reg.action == ACTION_TICK,
        sum_x_reg == '0 && sum_y_reg == '0)
    `HIDKC_ASSERT_NEXT(a_event_loads_result, stage_fire && has_result, result_valid_reg)
    `HIDKC_ASSERT_SAME(a_motion_nonzero,
        result_valid_reg && result_reg.event_kind == KIND_MOTION,
        result_reg.motion_x != 32'sd0 || result_reg.motion_y != 32'sd0)
    `HIDKC_ASSERT_NEXT(a_stage_held, stage_valid_reg && !stage_fire,
        stage_valid_reg && $stable(stage_reg))

endmodule

`default_nettype wire
